// ===== rtl/core/hhfm_pkg.sv =====
// ----------------------------------------------------------------------------
// hhfm_pkg
// Shared types, constants and the frame check for the heavy hitter meter.
// ----------------------------------------------------------------------------
package hhfm_pkg;

  localparam int TABLE_ENTRIES  = 256;
  localparam int WINDOW_PACKETS = 4;
  localparam int IDX_W          = $clog2(TABLE_ENTRIES);
  localparam int CNT_W          = $clog2(TABLE_ENTRIES + 1);
  localparam int MD_W           = $clog2(WINDOW_PACKETS);
  localparam int MIN_MD_LEN     = 42 + 20 * (WINDOW_PACKETS - 1);

  localparam logic [15:0] ETH_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [31:0] THR_RESET  = 32'd1024;
  localparam logic        REQ_HEADER = 1'b0;
  localparam logic        REQ_META   = 1'b1;

  typedef enum logic [2:0] {
    RSN_PASS      = 3'd0,
    RSN_SHORT_HDR = 3'd1,
    RSN_NOT_IPV4  = 3'd2,
    RSN_NOT_UDP   = 3'd3,
    RSN_SHORT_MD  = 3'd4,
    RSN_OVER      = 3'd5
  } reason_e;

  typedef enum logic [1:0] {
    TBL_IDLE,
    TBL_SCAN,
    TBL_ADD
  } tbl_state_e;

  // one flow table entry
  typedef struct packed {
    logic [63:0] addrs;
    logic [31:0] ports;
    logic [63:0] total;
  } entry_t;

  // lookup / update request from the front end
  typedef struct packed {
    logic        start;
    logic [63:0] addrs;
    logic [31:0] ports;
    logic [63:0] sum;
  } tbl_req_t;

  // completion back to the front end
  typedef struct packed {
    logic        done;
    logic [63:0] total;
    logic        full;
  } tbl_rsp_t;

  // header checks in priority order
  function automatic reason_e check_frame(logic [31:0] len, logic [15:0] eth,
                                          logic [7:0] proto);
    reason_e r;
    r = RSN_PASS;
    if (len < 32'd14)                 r = RSN_SHORT_HDR;
    else if (eth != ETH_IPV4)         r = RSN_NOT_IPV4;
    else if (len < 32'd34)            r = RSN_SHORT_HDR;
    else if (proto != PROTO_UDP)      r = RSN_NOT_UDP;
    else if (len < 32'd42)            r = RSN_SHORT_HDR;
    else if (len < 32'(MIN_MD_LEN))   r = RSN_SHORT_MD;
    return r;
  endfunction

endpackage

// ===== rtl/core/hhfm_table.sv =====
// ----------------------------------------------------------------------------
// hhfm_table
// Flow table in one synchronous RAM. Entries fill in order, so a fill count
// marks the valid ones; a lookup scans them one read per cycle.
// ----------------------------------------------------------------------------
module hhfm_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hhfm_pkg::tbl_req_t req_i,
  output hhfm_pkg::tbl_rsp_t rsp_o,
  output logic              busy_o
);

  localparam logic [hhfm_pkg::CNT_W-1:0] CNT_W_ENTRIES =
    hhfm_pkg::CNT_W'(hhfm_pkg::TABLE_ENTRIES);

  hhfm_pkg::entry_t mem_q [hhfm_pkg::TABLE_ENTRIES];
  hhfm_pkg::entry_t rdata_q;

  hhfm_pkg::tbl_state_e state_q, state_d;
  logic [hhfm_pkg::CNT_W-1:0] used_q, used_d;
  logic [hhfm_pkg::CNT_W-1:0] idx_q, idx_d;
  logic [hhfm_pkg::IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [hhfm_pkg::IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic                       rd_pend_q, rd_pend_d;
  logic [63:0] key_addrs_q, key_addrs_d;
  logic [31:0] key_ports_q, key_ports_d;
  logic [63:0] sum_q, sum_d;
  logic [63:0] hit_total_q, hit_total_d;
  logic        done_q, done_d;
  logic [63:0] total_q, total_d;
  logic        full_q, full_d;

  logic                       rd_en;
  logic [hhfm_pkg::IDX_W-1:0] rd_addr;
  logic                       wr_en;
  logic [hhfm_pkg::IDX_W-1:0] wr_addr;
  hhfm_pkg::entry_t           wr_data;
  logic                       hit;

  assign hit    = rd_pend_q && (rdata_q.addrs == key_addrs_q) &&
                  (rdata_q.ports == key_ports_q);
  assign busy_o = (state_q != hhfm_pkg::TBL_IDLE) || done_q;
  assign rsp_o  = '{done: done_q, total: total_q, full: full_q};

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hhfm_pkg::TBL_IDLE;
      used_q  <= '0;
      idx_q   <= '0;
      rd_pend_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      idx_q   <= idx_d;
      rd_pend_q <= rd_pend_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    hit_idx_q   <= hit_idx_d;
    key_addrs_q <= key_addrs_d;
    key_ports_q <= key_ports_d;
    sum_q       <= sum_d;
    hit_total_q <= hit_total_d;
    total_q     <= total_d;
    full_q      <= full_d;
  end

  // RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // scan sequencer
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    idx_d       = idx_q;
    rd_idx_d    = rd_idx_q;
    hit_idx_d   = hit_idx_q;
    rd_pend_d   = 1'b0;
    key_addrs_d = key_addrs_q;
    key_ports_d = key_ports_q;
    sum_d       = sum_q;
    hit_total_d = hit_total_q;
    done_d      = 1'b0;
    total_d     = total_q;
    full_d      = full_q;
    rd_en       = 1'b0;
    rd_addr     = idx_q[hhfm_pkg::IDX_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = used_q[hhfm_pkg::IDX_W-1:0];
    wr_data     = '{addrs: key_addrs_q, ports: key_ports_q, total: sum_q};
    case (state_q)
      hhfm_pkg::TBL_IDLE: begin
        if (req_i.start) begin
          key_addrs_d = req_i.addrs;
          key_ports_d = req_i.ports;
          sum_d       = req_i.sum;
          idx_d       = '0;
          state_d     = hhfm_pkg::TBL_SCAN;
        end
      end
      hhfm_pkg::TBL_SCAN: begin
        if (hit) begin
          hit_idx_d   = rd_idx_q;
          hit_total_d = rdata_q.total;
          state_d     = hhfm_pkg::TBL_ADD;
        end else if (idx_q < used_q) begin
          // issue the next read, compare next cycle
          rd_en     = 1'b1;
          rd_pend_d = 1'b1;
          rd_idx_d  = idx_q[hhfm_pkg::IDX_W-1:0];
          idx_d     = idx_q + 1'b1;
        end else if (!rd_pend_q) begin
          // miss: insert if room is left
          total_d = sum_q;
          done_d  = 1'b1;
          state_d = hhfm_pkg::TBL_IDLE;
          if (used_q < CNT_W_ENTRIES) begin
            wr_en  = 1'b1;
            used_d = used_q + 1'b1;
            full_d = 1'b0;
          end else begin
            full_d = 1'b1;
          end
        end
      end
      hhfm_pkg::TBL_ADD: begin
        wr_en         = 1'b1;
        wr_addr       = hit_idx_q;
        wr_data.total = sum_q + hit_total_q;
        total_d       = sum_q + hit_total_q;
        full_d        = 1'b0;
        done_d        = 1'b1;
        state_d       = hhfm_pkg::TBL_IDLE;
      end
      default: begin
        state_d = hhfm_pkg::TBL_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/heavy_hitter_flow_meter.sv =====
// ----------------------------------------------------------------------------
// heavy_hitter_flow_meter
// Per-flow byte meter: sums matching metadata per packet, accumulates into a
// flow table and reports a drop verdict on the packet's last item.
// ----------------------------------------------------------------------------
//  channel | signals                      | direction | transaction
//  --------+------------------------------+-----------+----------------------
//  in      | in_valid_i / in_stall_o      | input     | valid & !stall
//  out     | out_valid_o / out_stall_i    | output    | valid & !stall
//  cfg     | cfg_valid_i / cfg_ready_o    | input     | valid & ready
//
// Header and metadata items are taken whenever in_stall_o is low. A last item of a
// passing packet starts a table scan, one read per cycle through the RAM
// port; input stalls meanwhile. Failed packets report in the cycle after
// their last item. The output register holds a result while out_stall_i
// is high; besides the scan, input stalls whenever a held result is stalled.
// Reset empties the table at once through its fill count.
module heavy_hitter_flow_meter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic        last_i,
  input  logic [15:0] eth_type_i,
  input  logic [7:0]  ip_proto_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  input  logic [31:0] byte_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        drop_o,
  output logic [2:0]  reason_o,
  output logic [63:0] flow_bytes_o,
  output logic        table_full_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic        in_pkt_q, in_pkt_d;
  logic [hhfm_pkg::MD_W-1:0] md_q, md_d;
  hhfm_pkg::reason_e status_q, status_d;
  logic [63:0] cur_addrs_q, cur_addrs_d;
  logic [31:0] cur_ports_q, cur_ports_d;
  logic [63:0] sum_q, sum_d;
  logic [31:0] thr_q;
  logic        out_valid_q, out_valid_d;
  logic        drop_q, drop_d;
  hhfm_pkg::reason_e reason_q, reason_d;
  logic [63:0] flow_q, flow_d;
  logic        full_q, full_d;

  hhfm_pkg::tbl_req_t tbl_req;
  hhfm_pkg::tbl_rsp_t tbl_rsp;
  logic               tbl_busy;
  logic               acc;
  logic               fin;
  logic [63:0]        addrs;
  logic [31:0]        ports;
  hhfm_pkg::reason_e  chk;

  assign cfg_ready_o  = 1'b1;
  assign in_stall_o   = tbl_busy || (out_valid_q && out_stall_i);
  assign acc          = in_valid_i && !in_stall_o;
  assign addrs        = {src_addr_i, dst_addr_i};
  assign ports        = {src_port_i, dst_port_i};
  assign chk          = hhfm_pkg::check_frame(byte_count_i, eth_type_i, ip_proto_i);
  assign out_valid_o  = out_valid_q;
  assign drop_o       = drop_q;
  assign reason_o     = reason_q;
  assign flow_bytes_o = flow_q;
  assign table_full_o = full_q;

  hhfm_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .rsp_o  (tbl_rsp),
    .busy_o (tbl_busy)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pkt_q    <= 1'b0;
      md_q        <= '0;
      status_q    <= hhfm_pkg::RSN_PASS;
      cur_addrs_q <= '0;
      cur_ports_q <= '0;
      sum_q       <= '0;
      thr_q       <= hhfm_pkg::THR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      in_pkt_q    <= in_pkt_d;
      md_q        <= md_d;
      status_q    <= status_d;
      cur_addrs_q <= cur_addrs_d;
      cur_ports_q <= cur_ports_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    drop_q   <= drop_d;
    reason_q <= reason_d;
    flow_q   <= flow_d;
    full_q   <= full_d;
  end

  // item handling and result selection
  always_comb begin
    in_pkt_d    = in_pkt_q;
    md_d        = md_q;
    status_d    = status_q;
    cur_addrs_d = cur_addrs_q;
    cur_ports_d = cur_ports_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    drop_d      = drop_q;
    reason_d    = reason_q;
    flow_d      = flow_q;
    full_d      = full_q;
    fin         = 1'b0;
    tbl_req     = '{start: 1'b0, addrs: cur_addrs_d, ports: cur_ports_d, sum: sum_d};

    if (acc) begin
      if (req_type_i == hhfm_pkg::REQ_HEADER) begin
        in_pkt_d = 1'b1;
        md_d     = '0;
        status_d = chk;
        if (chk == hhfm_pkg::RSN_PASS) begin
          cur_addrs_d = addrs;
          cur_ports_d = ports;
          sum_d       = {32'd0, byte_count_i};
        end
        fin = last_i;
      end else if (in_pkt_q) begin
        if (md_q < hhfm_pkg::MD_W'(hhfm_pkg::WINDOW_PACKETS - 1)) begin
          md_d = md_q + 1'b1;
          if (status_q == hhfm_pkg::RSN_PASS && ip_proto_i == hhfm_pkg::PROTO_UDP &&
              addrs == cur_addrs_q && ports == cur_ports_q) begin
            sum_d = sum_q + {32'd0, byte_count_i};
          end
        end
        fin = last_i;
      end
    end

    tbl_req.addrs = cur_addrs_d;
    tbl_req.ports = cur_ports_d;
    tbl_req.sum   = sum_d;

    // end of packet: failed ones report now, passing ones go to the table
    if (fin) begin
      in_pkt_d = 1'b0;
      if (status_d != hhfm_pkg::RSN_PASS) begin
        out_valid_d = 1'b1;
        drop_d      = 1'b1;
        reason_d    = status_d;
        flow_d      = '0;
        full_d      = 1'b0;
        status_d    = hhfm_pkg::RSN_PASS;
      end else begin
        tbl_req.start = 1'b1;
      end
    end

    // table completion
    if (tbl_rsp.done) begin
      out_valid_d = 1'b1;
      flow_d      = tbl_rsp.total;
      full_d      = tbl_rsp.full;
      if (tbl_rsp.total >= {32'd0, thr_q}) begin
        drop_d   = 1'b1;
        reason_d = hhfm_pkg::RSN_OVER;
      end else begin
        drop_d   = 1'b0;
        reason_d = hhfm_pkg::RSN_PASS;
      end
    end
  end

endmodule

// ===== rtl/core/hhfm_checker.sv =====
// ----------------------------------------------------------------------------
// hhfm_checker
// Port-level checks on the meter's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module hhfm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        drop_o,
  input logic [2:0]  reason_o,
  input logic [63:0] flow_bytes_o,
  input logic        table_full_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // drop exactly when a reason is given
  a_drop_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drop_o == (reason_o != hhfm_pkg::RSN_PASS)))
    else $error("drop and reason disagree");

  // failed checks report no total and no table state
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reason_o != hhfm_pkg::RSN_PASS && reason_o != hhfm_pkg::RSN_OVER
    |-> flow_bytes_o == 64'd0 && !table_full_o)
    else $error("failed packet carries table data");

  // only defined reason codes
  a_reason_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> reason_o <= hhfm_pkg::RSN_OVER)
    else $error("undefined reason code");

endmodule

bind heavy_hitter_flow_meter hhfm_checker u_hhfm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .drop_o       (drop_o),
  .reason_o     (reason_o),
  .flow_bytes_o (flow_bytes_o),
  .table_full_o (table_full_o)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the heavy hitter flow meter: drives packets of
// header and metadata transactions with random bursts and output stalls,
// predicts each verdict from a private flow table and compares field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int DRAIN_CYCLES = hhfm_pkg::TABLE_ENTRIES + 64;

  typedef struct {
    logic        req;
    logic        last;
    logic [15:0] eth;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] bytes;
  } item_t;

  typedef struct {
    logic              drop;
    hhfm_pkg::reason_e reason;
    logic [63:0]       flow_bytes;
    logic              full;
  } verdict_t;

  // flow table predictor and queue of expected verdicts
  class flow_meter_board;
    logic [31:0]       threshold;
    bit                row_valid[hhfm_pkg::TABLE_ENTRIES];
    logic [63:0]       row_addrs[hhfm_pkg::TABLE_ENTRIES];
    logic [31:0]       row_ports[hhfm_pkg::TABLE_ENTRIES];
    logic [63:0]       row_total[hhfm_pkg::TABLE_ENTRIES];
    int                rows_used;
    logic [63:0]       cur_addrs;
    logic [31:0]       cur_ports;
    logic [63:0]       pkt_sum;
    hhfm_pkg::reason_e pkt_status;
    bit                in_pkt;
    int                md_seen;
    verdict_t          verdicts_due[$];
    int                errors;

    function new();
      threshold = hhfm_pkg::THR_RESET;
      rows_used = 0;
      cur_addrs = '0;
      cur_ports = '0;
      pkt_sum = '0;
      pkt_status = hhfm_pkg::RSN_PASS;
      in_pkt = 0;
      md_seen = 0;
      errors = 0;
      foreach (row_valid[i]) row_valid[i] = 0;
    endfunction

    function hhfm_pkg::reason_e frame_status(logic [31:0] len, logic [15:0] eth,
                                             logic [7:0] proto);
      if (len < 14) return hhfm_pkg::RSN_SHORT_HDR;
      if (eth != hhfm_pkg::ETH_IPV4) return hhfm_pkg::RSN_NOT_IPV4;
      if (len < 34) return hhfm_pkg::RSN_SHORT_HDR;
      if (proto != hhfm_pkg::PROTO_UDP) return hhfm_pkg::RSN_NOT_UDP;
      if (len < 42) return hhfm_pkg::RSN_SHORT_HDR;
      if (len < hhfm_pkg::MIN_MD_LEN) return hhfm_pkg::RSN_SHORT_MD;
      return hhfm_pkg::RSN_PASS;
    endfunction

    // accepted input transaction
    function void note_item(item_t it);
      logic [63:0] addrs;
      logic [31:0] ports;
      logic [63:0] total;
      bit          hit;
      verdict_t    v;
      addrs = {it.src, it.dst};
      ports = {it.sport, it.dport};
      if (it.req == hhfm_pkg::REQ_HEADER) begin
        in_pkt = 1;
        md_seen = 0;
        pkt_status = frame_status(it.bytes, it.eth, it.proto);
        if (pkt_status == hhfm_pkg::RSN_PASS) begin
          cur_addrs = addrs;
          cur_ports = ports;
          pkt_sum = {32'd0, it.bytes};
        end
      end else begin
        if (!in_pkt) return;
        if (md_seen < hhfm_pkg::WINDOW_PACKETS - 1) begin
          md_seen++;
          if (pkt_status == hhfm_pkg::RSN_PASS && it.proto == hhfm_pkg::PROTO_UDP &&
              addrs == cur_addrs && ports == cur_ports)
            pkt_sum += {32'd0, it.bytes};
        end
      end
      if (!it.last) return;
      in_pkt = 0;
      if (pkt_status != hhfm_pkg::RSN_PASS) begin
        v = '{1'b1, pkt_status, 64'd0, 1'b0};
        pkt_status = hhfm_pkg::RSN_PASS;
        verdicts_due.push_back(v);
        return;
      end
      total = pkt_sum;
      hit = 0;
      v.full = 0;
      for (int i = 0; i < hhfm_pkg::TABLE_ENTRIES; i++) begin
        if (row_valid[i] && row_addrs[i] == cur_addrs && row_ports[i] == cur_ports) begin
          total += row_total[i];
          row_total[i] = total;
          hit = 1;
          break;
        end
      end
      if (!hit) begin
        if (rows_used < hhfm_pkg::TABLE_ENTRIES) begin
          row_valid[rows_used] = 1;
          row_addrs[rows_used] = cur_addrs;
          row_ports[rows_used] = cur_ports;
          row_total[rows_used] = total;
          rows_used++;
        end else begin
          v.full = 1;
        end
      end
      v.drop = (total >= {32'd0, threshold});
      v.reason = v.drop ? hhfm_pkg::RSN_OVER : hhfm_pkg::RSN_PASS;
      v.flow_bytes = total;
      verdicts_due.push_back(v);
    endfunction

    // accepted output transaction
    function void check_verdict(verdict_t got);
      verdict_t exp_v;
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected verdict drop=%0b reason=%0d bytes=%0d", $time,
                 got.drop, got.reason, got.flow_bytes);
        errors++;
        return;
      end
      exp_v = verdicts_due.pop_front();
      if (got.drop !== exp_v.drop) begin
        $display("%0t: drop exp %0b got %0b", $time, exp_v.drop, got.drop);
        errors++;
      end
      if (got.reason !== exp_v.reason) begin
        $display("%0t: reason exp %0d got %0d", $time, exp_v.reason, got.reason);
        errors++;
      end
      if (got.flow_bytes !== exp_v.flow_bytes) begin
        $display("%0t: flow_bytes exp %0d got %0d", $time, exp_v.flow_bytes,
                 got.flow_bytes);
        errors++;
      end
      if (got.full !== exp_v.full) begin
        $display("%0t: table_full exp %0b got %0b", $time, exp_v.full, got.full);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  item_t       drv;
  logic        out_valid;
  logic        out_stall;
  logic        drop;
  logic [2:0]  reason;
  logic [63:0] flow_bytes;
  logic        table_full;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  flow_meter_board board;
  int          cycles;
  int          burst_left;
  int          stall_mode;
  int          hold_cycles;
  bit          hold_req;
  item_t       flow_pool[$];

  heavy_hitter_flow_meter u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .req_type_i   (drv.req),
    .last_i       (drv.last),
    .eth_type_i   (drv.eth),
    .ip_proto_i   (drv.proto),
    .src_addr_i   (drv.src),
    .dst_addr_i   (drv.dst),
    .src_port_i   (drv.sport),
    .dst_port_i   (drv.dport),
    .byte_count_i (drv.bytes),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .drop_o       (drop),
    .reason_o     (reason),
    .flow_bytes_o (flow_bytes),
    .table_full_o (table_full),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("** heavy_hitter_flow_meter: FAILED **");
      $finish;
    end
  end

  // receiver stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_cycles = 600;
      hold_req = 0;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= ((cycles % 7) < 4);
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_verdict('{drop, hhfm_pkg::reason_e'(reason), flow_bytes, table_full});
  end

  // one input transaction, with bursts and gaps on the sender side
  task automatic send(item_t it);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    drv <= it;
    do @(posedge clk); while (in_stall);
    board.note_item(it);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    while (board.verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [31:0] value);
    go_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.threshold = value;
  endtask

  function automatic item_t header(item_t key, logic [31:0] len, logic last);
    item_t it;
    it = key;
    it.req = hhfm_pkg::REQ_HEADER;
    it.last = last;
    it.eth = hhfm_pkg::ETH_IPV4;
    it.proto = hhfm_pkg::PROTO_UDP;
    it.bytes = len;
    return it;
  endfunction

  function automatic item_t meta(item_t key, logic [31:0] n, logic last);
    item_t it;
    it = key;
    it.req = hhfm_pkg::REQ_META;
    it.last = last;
    it.eth = 16'($urandom);
    it.proto = hhfm_pkg::PROTO_UDP;
    it.bytes = n;
    return it;
  endfunction

  function automatic item_t fresh_key();
    item_t k;
    k.src = $urandom;
    k.dst = $urandom;
    k.sport = 16'($urandom);
    k.dport = 16'($urandom);
    return k;
  endfunction

  // one random packet, mostly well formed
  task automatic random_packet();
    item_t key;
    item_t it;
    int    n_md;
    int    sel;
    logic [31:0] len;
    sel = $urandom_range(0, 99);
    if (sel < 4) begin
      // stray metadata outside a packet
      send(meta(fresh_key(), $urandom, 1'($urandom_range(0, 1))));
      return;
    end
    if (sel < 8) begin
      // header abandoned by the next header
      send(header(fresh_key(), $urandom_range(102, 1500), 1'b0));
    end
    if ($urandom_range(0, 1) == 0 || flow_pool.size() == 0) begin
      key = fresh_key();
      flow_pool.push_back(key);
    end else begin
      key = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
    end
    len = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(102, 1500);
    n_md = $urandom_range(0, 5);
    it = header(key, len, n_md == 0);
    sel = $urandom_range(0, 99);
    if (sel < 4) it.eth = 16'($urandom);
    else if (sel < 8) it.proto = 8'($urandom);
    else if (sel < 12) it.bytes = $urandom_range(0, 120);
    send(it);
    for (int m = 0; m < n_md; m++) begin
      it = meta(key, ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3000),
                m == n_md - 1);
      sel = $urandom_range(0, 99);
      if (sel < 8) it.proto = 8'($urandom);
      else if (sel < 14) it.src[$urandom_range(0, 31)] ^= 1'b1;
      else if (sel < 18) it.dport[$urandom_range(0, 15)] ^= 1'b1;
      send(it);
    end
  endtask

  initial begin
    item_t k;
    board = new();
    cycles = 0;
    burst_left = 0;
    stall_mode = 0;
    hold_cycles = 0;
    hold_req = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    drv = '{default: '0};
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: each frame check, limits of length, open cases
    k = fresh_key();
    send(header(k, 13, 1'b1));
    send(header(k, hhfm_pkg::MIN_MD_LEN - 1, 1'b1));
    send(header(k, 33, 1'b1));
    send(header(k, 41, 1'b1));
    send(header(k, 0, 1'b1));
    begin
      item_t b;
      b = header(k, 200, 1'b1);
      b.eth = 16'hFFFF;
      send(b);
      b = header(k, 200, 1'b1);
      b.proto = 8'd6;
      send(b);
    end
    send(meta(k, 32'hFFFF_FFFF, 1'b1));
    send(header(k, 500, 1'b0));
    send(header(k, hhfm_pkg::MIN_MD_LEN, 1'b0));
    send(meta(k, 100, 1'b0));
    send(meta(k, 32'hFFFF_FFFF, 1'b0));
    send(meta(k, 7, 1'b0));
    send(meta(k, 9999, 1'b0));
    send(meta(k, 5, 1'b1));
    send(header(k, 32'hFFFF_FFFF, 1'b1));
    send(header(fresh_key(), 1000, 1'b1));
    begin
      item_t mm;
      send(header(k, 300, 1'b0));
      mm = meta(k, 50, 1'b0);
      mm.proto = 8'd6;
      send(mm);
      send(meta(k, 60, 1'b1));
    end

    // random phases over several thresholds
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: write_threshold(32'd0);
        2: write_threshold(32'hFFFF_FFFF);
        3: write_threshold($urandom);
        4: write_threshold(32'd5000);
        default: ;
      endcase
      if (ph == 2) hold_req = 1;
      for (int n = 0; n < 110; n++) random_packet();
    end

    go_idle();
    if (board.verdicts_due.size() != 0) begin
      $display("%0t: %0d verdicts never seen", $time, board.verdicts_due.size());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("** heavy_hitter_flow_meter: PASSED **");
    end else begin
      $display("** heavy_hitter_flow_meter: FAILED **");
    end
    $finish;
  end

endmodule
